>>> sv/ctlru_pkg.sv
// Shared constants, codes and types for the cache tag lookup unit.
// No dependencies; the front end, sequencer and top refer to it by scoped names.
package ctlru_pkg;

  localparam int MAX_LINES_LOG2 = 6;
  localparam int SET_WAYS       = 4;
  localparam int TAG_W          = 32;
  localparam int ADDR_W         = 32;
  localparam int SHIFT_W        = 4;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 4;
  localparam int LINES_MIN_LOG2 = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SHIFT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINES_LOG2  = 2'd2;

  localparam logic [1:0] MODE_DIRECT    = 2'd0;
  localparam logic [1:0] MODE_SET_ASSOC = 2'd1;

  localparam logic [2:0] LINES_RESET = 3'd6;

  typedef struct packed {
    logic [1:0] map_mode;
    logic [3:0] block_shift;
    logic [2:0] lines_log2;
  } geom_t;

  function automatic int flog2(input int v);
    int r;
    r = 0;
    while ((2 << r) <= v) r++;
    return r;
  endfunction

  function automatic int store_depth(input int max_lg, input int ways);
    return (2 << max_lg) + ways;
  endfunction

endpackage

>>> sv/ctlru_front.sv
// Front end: splits a word address into set base, way count and tag.
// Depends on ctlru_pkg.
module ctlru_front #(
  parameter int MAX_LINES_LOG2 = ctlru_pkg::MAX_LINES_LOG2,
  parameter int SET_WAYS       = ctlru_pkg::SET_WAYS,
  parameter int AW             = 8
) (
  input  ctlru_pkg::geom_t                 geom_i,
  input  logic [ctlru_pkg::ADDR_W-1:0]     word_address_i,
  output logic [ctlru_pkg::TAG_W-1:0]      tag_o,
  output logic [AW-1:0]                    base_o,
  output logic [AW-1:0]                    ways_o
);

  localparam int WL = ctlru_pkg::flog2(SET_WAYS);
  localparam logic [ctlru_pkg::SHIFT_W-1:0] WLC  = ctlru_pkg::SHIFT_W'(WL);
  localparam logic [ctlru_pkg::SHIFT_W-1:0] MAXC = ctlru_pkg::SHIFT_W'(MAX_LINES_LOG2);
  localparam logic [ctlru_pkg::SHIFT_W-1:0] MINC =
    ctlru_pkg::SHIFT_W'(ctlru_pkg::LINES_MIN_LOG2);

  logic [ctlru_pkg::ADDR_W-1:0]  blk;
  logic [ctlru_pkg::ADDR_W-1:0]  set_idx;
  logic [ctlru_pkg::ADDR_W-1:0]  mask;
  logic [ctlru_pkg::SHIFT_W-1:0] lines_ext;
  logic [ctlru_pkg::SHIFT_W-1:0] lg;
  logic [ctlru_pkg::SHIFT_W-1:0] sb;

  always_comb begin
    blk       = word_address_i >> geom_i.block_shift;
    lines_ext = {1'b0, geom_i.lines_log2};
    if (lines_ext < MINC) begin
      lg = MINC;
    end else if (lines_ext > MAXC) begin
      lg = MAXC;
    end else begin
      lg = lines_ext;
    end
    unique case (geom_i.map_mode)
      ctlru_pkg::MODE_DIRECT: begin
        sb     = lg;
        ways_o = AW'(1);
      end
      ctlru_pkg::MODE_SET_ASSOC: begin
        sb     = (lg > WLC) ? lg - WLC : '0;
        ways_o = AW'(SET_WAYS);
      end
      default: begin
        sb     = '0;
        ways_o = AW'(1) << lg;
      end
    endcase
    mask    = (32'd1 << sb) - 32'd1;
    set_idx = blk & mask;
    tag_o   = blk >> sb;
    unique case (geom_i.map_mode)
      ctlru_pkg::MODE_DIRECT:    base_o = AW'(set_idx[MAX_LINES_LOG2-1:0]);
      ctlru_pkg::MODE_SET_ASSOC: base_o = AW'(AW'(set_idx[MAX_LINES_LOG2-1:0]) * AW'(SET_WAYS));
      default:                   base_o = '0;
    endcase
  end

endmodule

>>> sv/ctlru_queue.sv
// Two-entry queue between the front end and the lookup sequencer.
// Depends on no package.
module ctlru_queue #(
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  input  logic          pop_i,
  output logic [DW-1:0] data_o,
  output logic          full_o,
  output logic          empty_o
);

  logic [DW-1:0] slot_q [2];
  logic          wp_q, wp_d, rp_q, rp_d;
  logic [1:0]    cnt_q, cnt_d;

  always_comb begin
    wp_d  = wp_q ^ push_i;
    rp_d  = rp_q ^ pop_i;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= data_i;
    end
  end

  assign data_o  = slot_q[rp_q];
  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;

endmodule

>>> sv/ctlru_back.sv
// Lookup sequencer: scans a set in the line store, picks the way, ages ranks.
// Holds the line store memory and the hit counter. Depends on ctlru_pkg.
module ctlru_back #(
  parameter int AW    = 8,
  parameter int DEPTH = 132
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          flush_i,
  input  logic                          q_empty_i,
  input  logic [ctlru_pkg::TAG_W-1:0]   q_tag_i,
  input  logic [AW-1:0]                 q_base_i,
  input  logic [AW-1:0]                 q_ways_i,
  output logic                          pop_o,
  output logic                          clearing_o,
  output logic                          result_valid_o,
  output logic                          hit_o,
  output logic                          evicted_valid_o,
  output logic [ctlru_pkg::TAG_W-1:0]   evicted_tag_o,
  output logic [31:0]                   hit_count_o
);

  localparam int TW = ctlru_pkg::TAG_W;
  localparam int EW = 1 + AW + TW;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [EW-1:0] mem_q [DEPTH];
  logic [EW-1:0] rd_q;
  logic          we;
  logic [AW-1:0] wa, ra;
  logic [EW-1:0] wd;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] clr_q, clr_d, j_q, j_d;
  logic [TW-1:0] tag_q, tag_d;
  logic [AW-1:0] base_q, base_d, ways_q, ways_d;
  logic          rv_q, rv_d;
  logic [AW-1:0] ridx_q, ridx_d;
  logic          found_q, found_d, inv_found_q, inv_found_d;
  logic [AW-1:0] hw_q, hw_d, hrank_q, hrank_d, inv_q, inv_d;
  logic [AW-1:0] best_q, best_d, vict_q, vict_d, w_q, w_d, old_q, old_d;
  logic [TW-1:0] vtag_q, vtag_d;
  logic          evv_q, evv_d;
  logic [TW-1:0] evtag_q, evtag_d;
  logic          res_q, res_d, hit_q, hit_d, ev_valid_q, ev_valid_d;
  logic [TW-1:0] ev_tag_q, ev_tag_d;
  logic [31:0]   hits_q, hits_d;

  logic          rd_valid;
  logic [AW-1:0] rd_rank;
  logic [TW-1:0] rd_tag;

  assign rd_valid = rd_q[EW-1];
  assign rd_rank  = rd_q[TW +: AW];
  assign rd_tag   = rd_q[TW-1:0];
  assign ra       = base_q + j_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    j_d         = j_q;
    tag_d       = tag_q;
    base_d      = base_q;
    ways_d      = ways_q;
    rv_d        = 1'b0;
    ridx_d      = ridx_q;
    found_d     = found_q;
    inv_found_d = inv_found_q;
    hw_d        = hw_q;
    hrank_d     = hrank_q;
    inv_d       = inv_q;
    best_d      = best_q;
    vict_d      = vict_q;
    vtag_d      = vtag_q;
    w_d         = w_q;
    old_d       = old_q;
    evv_d       = evv_q;
    evtag_d     = evtag_q;
    res_d       = 1'b0;
    hit_d       = hit_q;
    ev_valid_d  = ev_valid_q;
    ev_tag_d    = ev_tag_q;
    hits_d      = hits_q;
    pop_o       = 1'b0;
    we          = 1'b0;
    wa          = '0;
    wd          = '0;
    unique case (state_q)
      S_CLEAR: begin
        we = 1'b1;
        wa = clr_q;
        if (clr_q == LAST) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (!q_empty_i) begin
          pop_o       = 1'b1;
          tag_d       = q_tag_i;
          base_d      = q_base_i;
          ways_d      = q_ways_i;
          j_d         = '0;
          found_d     = 1'b0;
          inv_found_d = 1'b0;
          best_d      = '0;
          vict_d      = '0;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (j_q < ways_q) begin
          rv_d   = 1'b1;
          ridx_d = j_q;
          j_d    = j_q + AW'(1);
        end
        if (rv_q) begin
          if (rd_valid && rd_tag == tag_q && !found_q) begin
            found_d = 1'b1;
            hw_d    = ridx_q;
            hrank_d = rd_rank;
          end
          if (!rd_valid && !inv_found_q) begin
            inv_found_d = 1'b1;
            inv_d       = ridx_q;
          end
          // lowest way wins a tie on rank
          if (ridx_q == '0 || rd_rank > best_q) begin
            best_d = rd_rank;
            vict_d = ridx_q;
            vtag_d = rd_tag;
          end
        end
        if (j_q == ways_q && !rv_q) begin
          w_d     = found_q ? hw_q : (inv_found_q ? inv_q : vict_q);
          old_d   = found_q ? hrank_q : (inv_found_q ? ways_q : best_q);
          evv_d   = !found_q && !inv_found_q;
          evtag_d = (!found_q && !inv_found_q) ? vtag_q : '0;
          j_d     = '0;
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        if (j_q < ways_q) begin
          rv_d   = 1'b1;
          ridx_d = j_q;
          j_d    = j_q + AW'(1);
        end
        // age every valid way that was more recent than the chosen one
        if (rv_q && ridx_q != w_q && rd_valid && rd_rank < old_q) begin
          we = 1'b1;
          wa = base_q + ridx_q;
          wd = {1'b1, rd_rank + AW'(1), rd_tag};
        end
        if (j_q == ways_q && !rv_q) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        we         = 1'b1;
        wa         = base_q + w_q;
        wd         = {1'b1, AW'(0), tag_q};
        res_d      = 1'b1;
        hit_d      = found_q;
        ev_valid_d = evv_q;
        ev_tag_d   = evtag_q;
        if (found_q && hits_q != '1) begin
          hits_d = hits_q + 32'd1;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
    if (flush_i) begin
      state_d = S_CLEAR;
      clr_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      rv_q    <= 1'b0;
      res_q   <= 1'b0;
      hits_q  <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      rv_q    <= rv_d;
      res_q   <= res_d;
      hits_q  <= hits_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q         <= j_d;
    tag_q       <= tag_d;
    base_q      <= base_d;
    ways_q      <= ways_d;
    ridx_q      <= ridx_d;
    found_q     <= found_d;
    inv_found_q <= inv_found_d;
    hw_q        <= hw_d;
    hrank_q     <= hrank_d;
    inv_q       <= inv_d;
    best_q      <= best_d;
    vict_q      <= vict_d;
    vtag_q      <= vtag_d;
    w_q         <= w_d;
    old_q       <= old_d;
    evv_q       <= evv_d;
    evtag_q     <= evtag_d;
    hit_q       <= hit_d;
    ev_valid_q  <= ev_valid_d;
    ev_tag_q    <= ev_tag_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rd_q <= mem_q[ra];
  end

  assign clearing_o      = state_q == S_CLEAR;
  assign result_valid_o  = res_q;
  assign hit_o           = hit_q;
  assign evicted_valid_o = ev_valid_q;
  assign evicted_tag_o   = ev_tag_q;
  assign hit_count_o     = hits_q;

  a_res_from_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q |-> $past(state_q) == S_WRITE)
    else $error("result strobe without a store write");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q && hit_q |-> !ev_valid_q)
    else $error("hit reported together with an eviction");

  a_evtag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q && !ev_valid_q |-> ev_tag_q == '0)
    else $error("evicted tag not zero without eviction");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_UPD) |-> j_q <= ways_q)
    else $error("way counter ran past the set");

endmodule

>>> sv/cache_tag_lookup_lru_unit.sv
// Cache tag lookup with LRU replacement: direct mapped, set associative or
// fully associative over the lines in use.
// Channels: an item (word_address_i) is taken when start is high and busy
// is low. One result per item is marked by result_valid_o, high for a single
// cycle; hit_o, evicted_valid_o, evicted_tag_o and hit_count_o hold it until
// the next result. The receiver cannot stall it.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 map
// mode, 1 block shift, 2 lines log2); write only while idle.
// Sequencing: an item is popped from the queue, then the sequencer scans the
// W ways of its set, makes a rank update pass over them, and writes the
// chosen way, where W is the way count of its set (1, SET_WAYS, or all lines
// in use). The scan and rank update read one line store entry per cycle over
// the store read port. The sequencer takes no new item until the last one is
// written; a two-entry queue lets two more items be taken meanwhile.
// Reset, and any write of map mode or lines log2, starts a clear of all
// DEPTH = 2^(MAX_LINES_LOG2+1) + SET_WAYS line store entries (132 by
// default), during which busy is high. The hit count survives a clear.
// Depends on ctlru_pkg, ctlru_front, ctlru_queue and ctlru_back.
module cache_tag_lookup_lru_unit #(
  parameter int MAX_LINES_LOG2 = ctlru_pkg::MAX_LINES_LOG2,
  parameter int SET_WAYS       = ctlru_pkg::SET_WAYS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [ctlru_pkg::ADDR_W-1:0]        word_address_i,
  input  logic                                cfg_we_i,
  input  logic [ctlru_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ctlru_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic                                result_valid_o,
  output logic                                hit_o,
  output logic                                evicted_valid_o,
  output logic [ctlru_pkg::TAG_W-1:0]         evicted_tag_o,
  output logic [31:0]                         hit_count_o
);

  localparam int DEPTH = ctlru_pkg::store_depth(MAX_LINES_LOG2, SET_WAYS);
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = ctlru_pkg::TAG_W;
  localparam int DW    = TW + 2 * AW;

  ctlru_pkg::geom_t geom_q, geom_d;
  logic             flush;
  logic [TW-1:0]    f_tag, q_tag;
  logic [AW-1:0]    f_base, f_ways, q_base, q_ways;
  logic [DW-1:0]    q_data;
  logic             push, pop, full, empty, clearing;

  always_comb begin
    geom_d = geom_q;
    flush  = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ctlru_pkg::REG_MAP_MODE: begin
          geom_d.map_mode = cfg_data_i[1:0];
          flush           = 1'b1;
        end
        ctlru_pkg::REG_BLOCK_SHIFT: begin
          geom_d.block_shift = cfg_data_i[3:0];
        end
        ctlru_pkg::REG_LINES_LOG2: begin
          geom_d.lines_log2 = cfg_data_i[2:0];
          flush             = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom_q.map_mode    <= ctlru_pkg::MODE_DIRECT;
      geom_q.block_shift <= '0;
      geom_q.lines_log2  <= ctlru_pkg::LINES_RESET;
    end else begin
      geom_q <= geom_d;
    end
  end

  assign busy = full || clearing;
  assign push = start && !busy;

  ctlru_front #(
    .MAX_LINES_LOG2 (MAX_LINES_LOG2),
    .SET_WAYS       (SET_WAYS),
    .AW             (AW)
  ) u_front (
    .geom_i         (geom_q),
    .word_address_i (word_address_i),
    .tag_o          (f_tag),
    .base_o         (f_base),
    .ways_o         (f_ways)
  );

  ctlru_queue #(
    .DW (DW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_tag, f_base, f_ways}),
    .pop_i   (pop),
    .data_o  (q_data),
    .full_o  (full),
    .empty_o (empty)
  );

  assign q_tag  = q_data[DW-1 -: TW];
  assign q_base = q_data[2*AW-1 -: AW];
  assign q_ways = q_data[AW-1:0];

  ctlru_back #(
    .AW    (AW),
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .flush_i         (flush),
    .q_empty_i       (empty),
    .q_tag_i         (q_tag),
    .q_base_i        (q_base),
    .q_ways_i        (q_ways),
    .pop_o           (pop),
    .clearing_o      (clearing),
    .result_valid_o  (result_valid_o),
    .hit_o           (hit_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_tag_o   (evicted_tag_o),
    .hit_count_o     (hit_count_o)
  );

endmodule
